// ----- rtl/lart_pkg.sv -----
// Package for the lock auto-release timer: widths, codes, word types and the
// legacy mode duration table. Depends on nothing; every other file uses it.
package lart_pkg;

  localparam int unsigned MS_W     = 32;
  localparam int unsigned DAY_W    = 9;
  localparam int unsigned MINUTE_W = 11;
  localparam int unsigned POLICY_W = 3;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned RELMIN_W = 16;
  localparam int unsigned CAUSE_W  = 3;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOCK_ON  = 2'd0,
    OP_LOCK_OFF = 2'd1,
    OP_TICK     = 2'd2,
    OP_IGNORE   = 2'd3
  } opcode_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE         = 3'd0,
    CAUSE_EXTERNAL_OFF = 3'd1,
    CAUSE_DURATION     = 3'd2,
    CAUSE_RELEASE_TIME = 3'd3,
    CAUSE_DAY_CHANGE   = 3'd4
  } cause_t;

  localparam logic [POLICY_W-1:0] POL_LEGACY       = 3'd0;
  localparam logic [POLICY_W-1:0] POL_DURATION     = 3'd1;
  localparam logic [POLICY_W-1:0] POL_TIME_OF_DAY  = 3'd2;
  localparam logic [POLICY_W-1:0] POL_DUR_OR_TIME  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_EXTERNAL     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NONE     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT_DAY = 4'd12;

  localparam logic [RELMIN_W-1:0] RELEASE_OFF = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MINUTE = 2'd3;

  typedef struct packed {
    logic [POLICY_W-1:0] policy;
    logic [MODE_W-1:0]   fallback_mode;
    logic [MS_W-1:0]     duration_ms;
    logic [RELMIN_W-1:0] release_minute;
  } cfg_t;

  typedef struct packed {
    logic                locked;
    logic [MS_W-1:0]     deadline;
    logic                act_valid;
    logic [DAY_W-1:0]    act_day;
    logic [MINUTE_W-1:0] act_minute;
  } lock_state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [MS_W-1:0]     now_ms;
    logic                has_time;
    logic [DAY_W-1:0]    day_of_year;
    logic [MINUTE_W-1:0] minute_of_day;
  } in_word_t;

  typedef struct packed {
    logic   lock_active;
    logic   lock_changed;
    cause_t release_cause;
  } out_word_t;

  // Legacy fixed durations in milliseconds, indexed by fallback mode.
  function automatic logic [MS_W-1:0] mode_ms(input logic [MODE_W-1:0] mode);
    logic [MS_W-1:0] ms;
    case (mode)
      4'd1:    ms = 32'd60000;
      4'd2:    ms = 32'd120000;
      4'd3:    ms = 32'd300000;
      4'd4:    ms = 32'd600000;
      4'd5:    ms = 32'd1200000;
      4'd6:    ms = 32'd1800000;
      4'd7:    ms = 32'd3600000;
      4'd8:    ms = 32'd7200000;
      4'd9:    ms = 32'd18000000;
      4'd10:   ms = 32'd28800000;
      4'd11:   ms = 32'd43200000;
      default: ms = '0;
    endcase
    return ms;
  endfunction

endpackage

// ----- rtl/lart_in_if.sv -----
// Input channel of the lock auto-release timer: valid, ready and one input word.
// Depends on lart_pkg for the field widths.
interface lart_in_if;
  logic                                valid;
  logic                                ready;
  logic [lart_pkg::OPCODE_W-1:0]       opcode;
  logic [lart_pkg::MS_W-1:0]           now_ms;
  logic                                has_time;
  logic [lart_pkg::DAY_W-1:0]          day_of_year;
  logic [lart_pkg::MINUTE_W-1:0]       minute_of_day;

  modport source (output valid, opcode, now_ms, has_time, day_of_year, minute_of_day,
                  input ready);
  modport sink (input valid, opcode, now_ms, has_time, day_of_year, minute_of_day,
                output ready);
  modport mon (input valid, ready, opcode, now_ms, has_time, day_of_year, minute_of_day);
endinterface

// ----- rtl/lart_out_if.sv -----
// Result channel of the lock auto-release timer: valid, ready and one result word.
// Depends on lart_pkg for the field widths.
interface lart_out_if;
  logic                         valid;
  logic                         ready;
  logic                         lock_active;
  logic                         lock_changed;
  logic [lart_pkg::CAUSE_W-1:0] release_cause;

  modport source (output valid, lock_active, lock_changed, release_cause, input ready);
  modport sink (input valid, lock_active, lock_changed, release_cause, output ready);
  modport mon (input valid, ready, lock_active, lock_changed, release_cause);
endinterface

// ----- rtl/lart_cfg_if.sv -----
// Configuration write channel: valid, ready, register index and write data.
// Depends on lart_pkg for the field widths.
interface lart_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lart_pkg::CFG_IDX_W-1:0]  index;
  logic [lart_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport mon (input valid, ready, index, data);
endinterface

// ----- rtl/lart_cfg_regs.sv -----
// Configuration register file of the lock auto-release timer.
// Depends on lart_pkg and lart_cfg_if.
module lart_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  lart_cfg_if.sink        cfg_ch,
  output lart_pkg::cfg_t  cfg_o
);

  lart_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy         <= lart_pkg::POL_LEGACY;
      cfg_r.fallback_mode  <= lart_pkg::MODE_NONE;
      cfg_r.duration_ms    <= '0;
      cfg_r.release_minute <= lart_pkg::RELEASE_OFF;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lart_pkg::REG_POLICY: begin
          cfg_r.policy <= cfg_ch.data[lart_pkg::POLICY_W-1:0];
        end
        lart_pkg::REG_FALLBACK_MODE: begin
          cfg_r.fallback_mode <= cfg_ch.data[lart_pkg::MODE_W-1:0];
        end
        lart_pkg::REG_DURATION_MS: begin
          cfg_r.duration_ms <= cfg_ch.data[lart_pkg::MS_W-1:0];
        end
        lart_pkg::REG_RELEASE_MINUTE: begin
          cfg_r.release_minute <= cfg_ch.data[lart_pkg::RELMIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/lart_eval.sv -----
// Next-state and result logic for one input word of the lock auto-release timer.
// Depends on lart_pkg.
module lart_eval (
  input  lart_pkg::cfg_t        cfg_i,
  input  lart_pkg::lock_state_t state_i,
  input  lart_pkg::in_word_t    word_i,
  output lart_pkg::lock_state_t state_nxt_o,
  output lart_pkg::out_word_t   result_o
);

  logic [lart_pkg::POLICY_W-1:0] pol;
  logic [lart_pkg::MS_W-1:0]     dur;
  logic [lart_pkg::MS_W-1:0]     elapsed;
  logic                          by_dur;
  logic                          by_time;
  logic                          day_change;
  lart_pkg::cause_t              cause;
  lart_pkg::lock_state_t         armed;
  lart_pkg::lock_state_t         nxt;

  assign pol = (cfg_i.policy > lart_pkg::POL_EXTERNAL) ? lart_pkg::POL_LEGACY : cfg_i.policy;

  always_comb begin
    if (pol == lart_pkg::POL_LEGACY) begin
      dur = lart_pkg::mode_ms(cfg_i.fallback_mode);
    end else if (pol == lart_pkg::POL_DURATION || pol == lart_pkg::POL_DUR_OR_TIME) begin
      dur = cfg_i.duration_ms;
    end else begin
      dur = '0;
    end
  end

  always_comb begin
    armed.locked     = 1'b1;
    armed.deadline   = (dur != '0) ? word_i.now_ms + dur : '0;
    armed.act_valid  = word_i.has_time;
    armed.act_day    = word_i.has_time ? word_i.day_of_year : '0;
    armed.act_minute = word_i.has_time ? word_i.minute_of_day : '0;
  end

  assign elapsed = word_i.now_ms - state_i.deadline;
  assign by_dur  = (state_i.deadline != '0) && !elapsed[lart_pkg::MS_W-1];

  always_comb begin
    by_time = word_i.has_time && (cfg_i.release_minute != lart_pkg::RELEASE_OFF) &&
              state_i.act_valid && (word_i.day_of_year >= state_i.act_day) &&
              !((word_i.day_of_year == state_i.act_day) &&
                (cfg_i.release_minute <= {5'd0, state_i.act_minute})) &&
              ({5'd0, word_i.minute_of_day} >= cfg_i.release_minute);
  end

  assign day_change = (cfg_i.fallback_mode == lart_pkg::MODE_NEXT_DAY) && word_i.has_time &&
                      state_i.act_valid && (word_i.day_of_year != state_i.act_day);

  always_comb begin
    nxt   = state_i;
    cause = lart_pkg::CAUSE_NONE;
    case (word_i.opcode)
      lart_pkg::OP_LOCK_ON: begin
        nxt = armed;
      end
      lart_pkg::OP_LOCK_OFF: begin
        if (state_i.locked) begin
          cause = lart_pkg::CAUSE_EXTERNAL_OFF;
        end
        nxt = '0;
      end
      lart_pkg::OP_TICK: begin
        if (state_i.locked && pol != lart_pkg::POL_EXTERNAL) begin
          if (pol != lart_pkg::POL_LEGACY) begin
            if ((pol == lart_pkg::POL_TIME_OF_DAY || pol == lart_pkg::POL_DUR_OR_TIME) &&
                by_time) begin
              cause = lart_pkg::CAUSE_RELEASE_TIME;
            end else if (by_dur) begin
              cause = lart_pkg::CAUSE_DURATION;
            end
          end else if (cfg_i.fallback_mode != lart_pkg::MODE_NONE) begin
            if (state_i.deadline != '0) begin
              if (by_dur) begin
                cause = lart_pkg::CAUSE_DURATION;
              end
            end else if (day_change) begin
              cause = lart_pkg::CAUSE_DAY_CHANGE;
            end
          end
          if (cause != lart_pkg::CAUSE_NONE) begin
            nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign state_nxt_o            = nxt;
  assign result_o.lock_active   = nxt.locked;
  assign result_o.lock_changed  = nxt.locked != state_i.locked;
  assign result_o.release_cause = cause;

endmodule

// ----- rtl/lock_auto_release_timer_unit.sv -----
// Lock auto-release timer, top level: input register, evaluation, result register.
// An accepted word goes into the input register and, once it advances, its result word
// is held in the result register, where it is offered on the result channel.
// Throughput: one word per cycle while the result channel takes its words; while a
// result word is stalled, the input side accepts only into an empty input register.
// Reset (rst_n, synchronous): lock state and valid flags cleared, release minute disabled, other config 0.
module lock_auto_release_timer_unit (
  input  logic       clk,
  input  logic       rst_n,
  lart_in_if.sink    in_ch,
  lart_out_if.source out_ch,
  lart_cfg_if.sink   cfg_ch
);

  lart_pkg::cfg_t        cfg;
  lart_pkg::lock_state_t state_r;
  lart_pkg::lock_state_t state_nxt;
  lart_pkg::in_word_t    in_word_r;
  lart_pkg::out_word_t   result;
  lart_pkg::out_word_t   out_word_r;
  logic                  in_valid_r;
  logic                  out_valid_r;
  logic                  advance;

  lart_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  lart_eval u_eval (
    .cfg_i       (cfg),
    .state_i     (state_r),
    .word_i      (in_word_r),
    .state_nxt_o (state_nxt),
    .result_o    (result)
  );

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.opcode        <= lart_pkg::opcode_t'(in_ch.opcode);
      in_word_r.now_ms        <= in_ch.now_ms;
      in_word_r.has_time      <= in_ch.has_time;
      in_word_r.day_of_year   <= in_ch.day_of_year;
      in_word_r.minute_of_day <= in_ch.minute_of_day;
    end
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.lock_active   = out_word_r.lock_active;
  assign out_ch.lock_changed  = out_word_r.lock_changed;
  assign out_ch.release_cause = out_word_r.release_cause;

endmodule

// ----- rtl/lart_checker.sv -----
// Port-level checker for the lock auto-release timer and its bind to the top level.
// Depends on lart_pkg and the result channel of the top level.
module lart_port_checks (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         lock_active,
  input logic                         lock_changed,
  input logic [lart_pkg::CAUSE_W-1:0] release_cause
);

  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("Result word valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lock_active) &&
    $stable(lock_changed) && $stable(release_cause))
    else $error("Stalled result word changed.");

  a_release_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (release_cause != lart_pkg::CAUSE_NONE) |->
    !lock_active && lock_changed)
    else $error("Release reported without a falling lock.");

  a_lock_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lock_active |-> release_cause == lart_pkg::CAUSE_NONE)
    else $error("Release cause reported while lock held.");

  a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> release_cause <= lart_pkg::CAUSE_DAY_CHANGE)
    else $error("Undefined release cause.");

endmodule

bind lock_auto_release_timer_unit lart_port_checks u_lart_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .lock_active   (out_ch.lock_active),
  .lock_changed  (out_ch.lock_changed),
  .release_cause (out_ch.release_cause)
);
